>>> src/frame_crc8_crc16_checker_core_macros.svh
// ----------------------------------------------------------------------------
// Frame CRC checker assertion macros
// Shared concurrent assertion forms, clocked on clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef FRAME_CRC8_CRC16_CHECKER_CORE_MACROS_SVH
`define FRAME_CRC8_CRC16_CHECKER_CORE_MACROS_SVH

// same-cycle implication
`define FCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/fcc_pkg.sv
// ----------------------------------------------------------------------------
// Frame CRC checker package
// Item types, status codes and the CRC-8 / CRC-16 byte update functions.
// ----------------------------------------------------------------------------
package fcc_pkg;

  localparam logic [7:0]  CRC8_INIT     = 8'hFF;
  localparam logic [7:0]  CRC8_POLY     = 8'h8C;
  localparam logic [15:0] CRC16_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC16_POLY    = 16'h8408;
  localparam logic [7:0]  MAX_LEN_RESET = 8'd45;
  localparam logic [7:0]  MIN_LEN       = 8'd5;
  localparam logic [7:0]  HDR_CRC_POS   = 8'd4;
  localparam logic [7:0]  BODY_START    = 8'd2;
  localparam logic [7:0]  COUNT_MAX     = 8'd255;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_LEN_ERR  = 2'd1,
    ST_HDR_ERR  = 2'd2,
    ST_BODY_ERR = 2'd3
  } check_status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    check_status_t check_status;
    logic [7:0]    frame_length;
    logic [15:0]   computed_crc16;
  } out_item_t;

  typedef struct packed {
    logic [7:0] max_frame_length;
  } cfg_item_t;

  typedef struct packed {
    logic     step;
    in_item_t item;
  } frame_ctl_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ CRC8_POLY) : (v >> 1);
    end
    return v;
  endfunction

  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] low;
    low = {8'h00, crc[7:0] ^ b};
    for (int i = 0; i < 8; i++) begin
      low = low[0] ? ((low >> 1) ^ CRC16_POLY) : (low >> 1);
    end
    return (crc >> 8) ^ low;
  endfunction

endpackage

>>> src/fcc_chan_if.sv
// ----------------------------------------------------------------------------
// Frame CRC checker channel
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface fcc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> src/fcc_frame_eval.sv
// ----------------------------------------------------------------------------
// Frame CRC checker frame state
// Running CRC-8 header check, delayed CRC-16 body check, byte counter and
// the end-of-frame verdict for the byte being stepped in.
// ----------------------------------------------------------------------------
module fcc_frame_eval (
  input  logic               clk,
  input  logic               rst_n,
  input  fcc_pkg::frame_ctl_t ctl,
  input  logic [7:0]         max_len,
  output fcc_pkg::out_item_t result
);
  import fcc_pkg::*;

  logic [7:0]  count_r, count_nxt;
  logic [7:0]  hdr_crc_r, hdr_crc_nxt;
  logic        hdr_good_r, hdr_good_nxt;
  logic [15:0] body_crc_r, body_crc_nxt;
  logic [7:0]  dly0_r, dly1_r;
  logic [7:0]  b;
  logic [15:0] received;

  assign b = ctl.item.data_byte;

  always_comb begin
    hdr_crc_nxt  = hdr_crc_r;
    hdr_good_nxt = hdr_good_r;
    body_crc_nxt = body_crc_r;
    if (count_r < HDR_CRC_POS) begin
      hdr_crc_nxt = crc8_update(hdr_crc_r, b);
    end else if (count_r == HDR_CRC_POS) begin
      hdr_good_nxt = (b == hdr_crc_r);
    end
    if (count_r >= BODY_START) begin
      body_crc_nxt = crc16_update(body_crc_r, dly0_r);
    end
    count_nxt = (count_r == COUNT_MAX) ? COUNT_MAX : count_r + 8'd1;
    received  = {b, dly1_r};

    result.frame_length   = count_nxt;
    result.computed_crc16 = body_crc_nxt;
    priority if (count_nxt < MIN_LEN || count_nxt > max_len) begin
      result.check_status = ST_LEN_ERR;
    end else if (!hdr_good_nxt) begin
      result.check_status = ST_HDR_ERR;
    end else if (received != body_crc_nxt) begin
      result.check_status = ST_BODY_ERR;
    end else begin
      result.check_status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      hdr_crc_r  <= CRC8_INIT;
      hdr_good_r <= 1'b0;
      body_crc_r <= CRC16_INIT;
      dly0_r     <= '0;
      dly1_r     <= '0;
    end else if (ctl.step) begin
      if (ctl.item.last_byte) begin
        count_r    <= '0;
        hdr_crc_r  <= CRC8_INIT;
        hdr_good_r <= 1'b0;
        body_crc_r <= CRC16_INIT;
        dly0_r     <= '0;
        dly1_r     <= '0;
      end else begin
        count_r    <= count_nxt;
        hdr_crc_r  <= hdr_crc_nxt;
        hdr_good_r <= hdr_good_nxt;
        body_crc_r <= body_crc_nxt;
        dly0_r     <= dly1_r;
        dly1_r     <= b;
      end
    end
  end

endmodule

>>> src/frame_crc8_crc16_checker_core.sv
// ----------------------------------------------------------------------------
// Frame CRC checker core
// Checks a byte stream frame: CRC-8 over the header, CRC-16 over the body,
// length against a minimum and a configured maximum; one status per frame.
//
//   channel  dir  payload                                         transfer
//   in_chan  in   data_byte, last_byte                            one byte
//   out_chan out  check_status, frame_length, computed_crc16      one frame
//   cfg_chan in   max_frame_length                                reg write
//
// One byte per cycle sustained, except when a last byte waits on a full result
// register; a status is computed from the input register and held in the result register.
// Only a last byte waits on a full result register; other bytes pass freely.
// Synchronous active-low reset clears frame state, max length returns to 45.
// ----------------------------------------------------------------------------
module frame_crc8_crc16_checker_core (
  input  logic clk,
  input  logic rst_n,
  fcc_chan_if.sink   in_chan,
  fcc_chan_if.source out_chan,
  fcc_chan_if.sink   cfg_chan
);
  import fcc_pkg::*;

  logic       in_v_r;
  in_item_t   in_item_r;
  logic       step;
  logic       out_v_r;
  out_item_t  out_item_r;
  out_item_t  result;
  logic [7:0] max_len_r;
  frame_ctl_t ctl;
  in_item_t   in_item;
  cfg_item_t  cfg_item;

  assign in_item  = in_chan.payload;
  assign cfg_item = cfg_chan.payload;

  assign step           = in_v_r && (!in_item_r.last_byte || !out_v_r || out_chan.ready);
  assign in_chan.ready  = !in_v_r || step;
  assign cfg_chan.ready = 1'b1;

  assign ctl.step = step;
  assign ctl.item = in_item_r;

  fcc_frame_eval u_eval (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .max_len (max_len_r),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      max_len_r <= MAX_LEN_RESET;
    end else begin
      if (in_chan.ready) begin
        in_v_r <= in_chan.valid;
      end
      if (step && in_item_r.last_byte) begin
        out_v_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_chan.valid) begin
        max_len_r <= cfg_item.max_frame_length;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_item_r <= in_item;
    end
    if (step && in_item_r.last_byte) begin
      out_item_r <= result;
    end
  end

  assign out_chan.valid   = out_v_r;
  assign out_chan.payload = out_item_r;

endmodule

>>> src/fcc_checker.sv
// ----------------------------------------------------------------------------
// Frame CRC checker port checks
// Watches the result channel of the core: a stalled result holds, and status, length and CRC-16 agree.
// ----------------------------------------------------------------------------
`include "frame_crc8_crc16_checker_core_macros.svh"

module fcc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input fcc_pkg::out_item_t out_item
);
  import fcc_pkg::*;

  `FCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "result changed while stalled")
  `FCC_ASSERT_NOW(a_short_len, out_valid && out_item.frame_length < MIN_LEN, out_item.check_status == ST_LEN_ERR, "short frame not flagged")
  `FCC_ASSERT_NOW(a_empty_body, out_valid && out_item.frame_length < 8'd3, out_item.computed_crc16 == CRC16_INIT, "crc16 moved with no body byte")
  `FCC_ASSERT_NOW(a_len_nonzero, out_valid, out_item.frame_length != 8'd0, "zero frame length reported")

endmodule

bind frame_crc8_crc16_checker_core fcc_checker u_fcc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_item  (out_chan.payload)
);
